@@ src/cih_pkg.sv @@
// Shared types and constants for the coincidence interval histogram.
// Used by every module under src; no dependencies of its own.
package cih_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHARGE_W     = 16;
    localparam int STAMP_W      = 64;
    localparam int WIDTH_W      = 40;
    localparam int COUNT_W      = 32;
    localparam int BIN_FIELD_W  = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'b1;

    localparam logic [CHARGE_W-1:0] THRESHOLD_RESET = 16'd150;
    localparam logic [WIDTH_W-1:0]  BIN_WIDTH_RESET = 40'd2500000000;

    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [CHARGE_W-1:0]    charge_a;
        logic [CHARGE_W-1:0]    charge_b;
        logic [CHARGE_W-1:0]    charge_c;
        logic [CHARGE_W-1:0]    charge_d;
        logic [STAMP_W-1:0]     stamp_a;
        logic [STAMP_W-1:0]     stamp_b;
        logic [STAMP_W-1:0]     stamp_c;
        logic [STAMP_W-1:0]     stamp_d;
        logic [BIN_FIELD_W-1:0] read_bin;
    } t_in_item;

    typedef struct packed {
        logic                   coincidence;
        logic [STAMP_W-1:0]     arrival_time;
        logic signed [63:0]     interval;
        logic                   interval_valid;
        logic [BIN_FIELD_W-1:0] bin_hit;
        logic                   in_range;
        logic [COUNT_W-1:0]     bin_count;
        logic [COUNT_W-1:0]     event_count;
    } t_out_item;

    // What one channel lane reports to the merge tree
    typedef struct packed {
        logic               vld;
        logic               over;
        logic [STAMP_W-1:0] stamp;
    } t_lane_res;

    // Merged view of the whole event
    typedef struct packed {
        logic               vld;
        logic               all_over;
        logic [STAMP_W-1:0] arrival;
    } t_merge_res;

endpackage

@@ src/cih_lane.sv @@
// One channel lane: threshold compare of a charge, timestamp carried along.
// Depends on cih_pkg.
module cih_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [cih_pkg::CHARGE_W-1:0] i_charge,
    input  logic [cih_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [cih_pkg::CHARGE_W-1:0] i_threshold,
    output cih_pkg::t_lane_res           o_res
);

    cih_pkg::t_lane_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld <= i_valid;
        end
        if (i_valid) begin
            r_res.over  <= (i_charge > i_threshold);
            r_res.stamp <= i_stamp;
        end
    end

    assign o_res = r_res;

endmodule

@@ src/cih_merge.sv @@
// Registered two-level tree that merges the lanes: AND of the threshold
// flags and minimum of the timestamps. Depends on cih_pkg.
module cih_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cih_pkg::t_lane_res  i_lane [cih_pkg::NUM_CHANNELS],
    output cih_pkg::t_merge_res o_res
);

    localparam int HALF = cih_pkg::NUM_CHANNELS / 2;

    cih_pkg::t_lane_res  r_lvl1 [HALF];
    cih_pkg::t_lane_res  n_lvl1 [HALF];
    cih_pkg::t_merge_res r_res;

    always_comb begin
        for (int i = 0; i < HALF; i++) begin
            n_lvl1[i].vld   = i_lane[2*i].vld;
            n_lvl1[i].over  = i_lane[2*i].over & i_lane[2*i+1].over;
            n_lvl1[i].stamp = (i_lane[2*i+1].stamp < i_lane[2*i].stamp) ?
                              i_lane[2*i+1].stamp : i_lane[2*i].stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HALF; i++) begin
                r_lvl1[i].vld <= 1'b0;
            end
            r_res.vld <= 1'b0;
        end else begin
            for (int i = 0; i < HALF; i++) begin
                r_lvl1[i].vld <= n_lvl1[i].vld;
            end
            r_res.vld <= r_lvl1[0].vld;
        end
        for (int i = 0; i < HALF; i++) begin
            r_lvl1[i].over  <= n_lvl1[i].over;
            r_lvl1[i].stamp <= n_lvl1[i].stamp;
        end
        r_res.all_over <= r_lvl1[0].over & r_lvl1[1].over;
        r_res.arrival  <= (r_lvl1[1].stamp < r_lvl1[0].stamp) ?
                          r_lvl1[1].stamp : r_lvl1[0].stamp;
    end

    assign o_res = r_res;

endmodule

@@ src/cih_divider.sv @@
// Restoring divider: 64-bit dividend by 40-bit divisor, one quotient bit
// per cycle. Depends on cih_pkg.
module cih_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cih_pkg::STAMP_W-1:0] i_dividend,
    input  logic [cih_pkg::WIDTH_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [cih_pkg::STAMP_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(cih_pkg::STAMP_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [cih_pkg::WIDTH_W-1:0]   r_rem;
    logic [cih_pkg::WIDTH_W-1:0]   r_div;
    logic [cih_pkg::STAMP_W-1:0]   r_quo;
    logic [cih_pkg::WIDTH_W:0]     w_rem_sh;
    logic [cih_pkg::WIDTH_W:0]     w_sub;
    logic                          w_ge;

    // Shift the next dividend bit in, try one subtraction
    assign w_rem_sh = {r_rem, r_quo[cih_pkg::STAMP_W-1]};
    assign w_sub    = w_rem_sh - {1'b0, r_div};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(cih_pkg::STAMP_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[cih_pkg::WIDTH_W-1:0] : w_rem_sh[cih_pkg::WIDTH_W-1:0];
            r_quo <= {r_quo[cih_pkg::STAMP_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/coincidence_interval_histogram.sv @@
// Coincidence interval histogram, top level.
// Depends on cih_pkg, cih_lane, cih_merge and cih_divider.
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) takes one request
//   at a time: a detector event or a read of one histogram bin. Every request
//   gives exactly one result on the output channel (o_out_valid /
//   i_out_ready, payload o_out), in request order.
//   Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
//   always ready; write it only while no request is in flight.
// Path from input transfer to o_out_valid: a bin read passes S_RDREQ and
//   S_RDDATA; an event passes the lane and merge registers; an interval that
//   is divided adds the divider steps, and a binned event the bin read-modify-write.
// Throughput: one request at a time; the next request is taken as soon as
//   the previous result sits in the output register.
// Reset: synchronous, active low. Afterwards the bin memory is cleared, one
//   bin per cycle over all NUM_BINS bins, with o_in_ready low; configuration
//   writes are taken during that pass.
// Receiver stall: the result holds in the output register; the block takes
//   one more request and waits with its result until the register frees.
module coincidence_interval_histogram #(
    parameter int NUM_BINS = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cih_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cih_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cih_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cih_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [cih_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_MERGE  = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_BINRD  = 9'b000010000,
        S_BINWR  = 9'b000100000,
        S_RDREQ  = 9'b001000000,
        S_RDDATA = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    function automatic logic [cih_pkg::COUNT_W-1:0] sat_inc(
        input logic [cih_pkg::COUNT_W-1:0] v
    );
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    t_state                           r_state;
    logic [BIN_W-1:0]                 r_clr_idx;
    logic [cih_pkg::CHARGE_W-1:0]     r_threshold;
    logic [cih_pkg::WIDTH_W-1:0]      r_bin_width;
    logic [cih_pkg::STAMP_W-1:0]      r_prev;
    logic                             r_have_prev;
    logic [cih_pkg::COUNT_W-1:0]      r_total;
    logic [BIN_W-1:0]                 r_addr;
    logic                             r_rd_ok;
    logic [cih_pkg::COUNT_W-1:0]      r_mem [NUM_BINS];
    logic [cih_pkg::COUNT_W-1:0]      r_rdata;
    cih_pkg::t_out_item               r_res;
    cih_pkg::t_out_item               r_out;
    logic                             r_out_valid;

    logic                             w_in_xfer;
    logic                             w_out_free;
    logic                             w_out_load;
    cih_pkg::t_out_item               w_out_next;
    logic                             w_mem_we;
    logic [BIN_W-1:0]                 w_mem_waddr;
    logic [cih_pkg::COUNT_W-1:0]      w_mem_wdata;
    logic [cih_pkg::STAMP_W-1:0]      w_diff;
    logic                             w_div_start;
    logic                             w_div_done;
    logic [cih_pkg::STAMP_W-1:0]      w_quotient;
    logic [cih_pkg::CHARGE_W-1:0]     w_charge [cih_pkg::NUM_CHANNELS];
    logic [cih_pkg::STAMP_W-1:0]      w_stamp  [cih_pkg::NUM_CHANNELS];
    logic                             w_lane_start;
    cih_pkg::t_lane_res               w_lane [cih_pkg::NUM_CHANNELS];
    cih_pkg::t_merge_res              w_merge;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_xfer    = i_in_valid & o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_out_load   = (r_state == S_DONE) && w_out_free;
    assign o_cfg_ready  = 1'b1;
    assign w_lane_start = w_in_xfer && (i_in.req_type == cih_pkg::REQ_EVENT);

    assign w_charge[0] = i_in.charge_a;
    assign w_charge[1] = i_in.charge_b;
    assign w_charge[2] = i_in.charge_c;
    assign w_charge[3] = i_in.charge_d;
    assign w_stamp[0]  = i_in.stamp_a;
    assign w_stamp[1]  = i_in.stamp_b;
    assign w_stamp[2]  = i_in.stamp_c;
    assign w_stamp[3]  = i_in.stamp_d;

    for (genvar g = 0; g < cih_pkg::NUM_CHANNELS; g++) begin : g_lane
        cih_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_lane_start),
            .i_charge    (w_charge[g]),
            .i_stamp     (w_stamp[g]),
            .i_threshold (r_threshold),
            .o_res       (w_lane[g])
        );
    end

    cih_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (w_lane),
        .o_res   (w_merge)
    );

    assign w_diff      = w_merge.arrival - r_prev;
    assign w_div_start = (r_state == S_MERGE) && w_merge.vld && w_merge.all_over &&
                         r_have_prev && !w_diff[cih_pkg::STAMP_W-1] &&
                         (r_bin_width != '0);

    cih_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff),
        .i_divisor  (r_bin_width),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Bin memory: one write port, one registered read port
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = sat_inc(r_rdata);
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_idx;
            w_mem_wdata = '0;
        end else if (r_state == S_BINWR) begin
            w_mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cih_pkg::THRESHOLD_RESET;
            r_bin_width <= cih_pkg::BIN_WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cih_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[cih_pkg::CHARGE_W-1:0];
                cih_pkg::CFG_BIN_WIDTH: r_bin_width <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        w_out_next             = r_res;
        w_out_next.event_count = r_total;
    end

    // Output register: load a finished result, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_total     <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == BIN_W'(NUM_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_res <= '0;
                        if (i_in.req_type == cih_pkg::REQ_READ) begin
                            r_addr  <= BIN_W'(i_in.read_bin);
                            r_rd_ok <= (32'(i_in.read_bin) < 32'(NUM_BINS));
                            r_state <= S_RDREQ;
                        end else begin
                            r_state <= S_MERGE;
                        end
                    end
                end
                S_MERGE: begin
                    if (w_merge.vld) begin
                        if (!w_merge.all_over) begin
                            r_state <= S_DONE;
                        end else begin
                            r_total              <= sat_inc(r_total);
                            r_prev               <= w_merge.arrival;
                            r_have_prev          <= 1'b1;
                            r_res.coincidence    <= 1'b1;
                            r_res.arrival_time   <= w_merge.arrival;
                            r_res.interval_valid <= r_have_prev;
                            r_res.interval       <= r_have_prev ? w_diff : '0;
                            r_state              <= w_div_start ? S_DIV : S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_quotient < 64'(NUM_BINS)) begin
                            r_addr        <= BIN_W'(w_quotient);
                            r_res.bin_hit <= w_quotient[cih_pkg::BIN_FIELD_W-1:0];
                            r_state       <= S_BINRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_BINRD: begin
                    r_state <= S_BINWR;
                end
                S_BINWR: begin
                    r_res.in_range <= 1'b1;
                    r_state        <= S_DONE;
                end
                S_RDREQ: begin
                    r_state <= S_RDDATA;
                end
                S_RDDATA: begin
                    r_res.bin_count <= r_rd_ok ? r_rdata : '0;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    // Hold the result until the output register frees
                    if (w_out_free) begin
                        r_out   <= w_out_next;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_in_range_needs_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.in_range |->
            o_out.coincidence && o_out.interval_valid && !o_out.interval[63])
        else $error("binned result without a valid non-negative interval");

    a_bin_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.in_range |-> 32'(o_out.bin_hit) < 32'(NUM_BINS))
        else $error("bin index beyond histogram top");

    a_plain_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.coincidence |->
            o_out.arrival_time == '0 && !o_out.interval_valid && !o_out.in_range)
        else $error("non-coincident result carries event fields");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_start_when_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_start |=> r_state == S_MERGE)
        else $error("event transfer did not enter the merge wait");
`endif

endmodule
